// ===== rtl/core/linear_chirp_tone_generator_core_assert.svh =====
// Assertion macros shared by the chirp tone generator RTL.
`ifndef LINEAR_CHIRP_TONE_GENERATOR_CORE_ASSERT_SVH
`define LINEAR_CHIRP_TONE_GENERATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LCTG_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define LCTG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/lctg_pkg.sv =====
// Shared types, constants and the sine table function of the chirp tone generator.
`default_nettype none

package lctg_pkg;

   localparam int PHASE_W       = 32;
   localparam int ENV_W         = 32;
   localparam int START_INC_W   = 31;
   localparam int ENV_STEP_W    = 31;
   localparam int FRAME_COUNT_W = 20;
   localparam int VOLUME_W      = 16;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int SINE_MAG_W    = 15;

   localparam logic [ENV_W-1:0] ENV_ONE = 32'h8000_0000;
   localparam logic [63:0]      PI_Q30  = 64'd3373259426;
   localparam logic [63:0]      ONE_Q30 = 64'd1 << 30;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_START_INCREMENT = 3'd0,
      CSR_INCREMENT_STEP  = 3'd1,
      CSR_ENVELOPE_STEP   = 3'd2,
      CSR_FRAME_COUNT     = 3'd3,
      CSR_VOLUME          = 3'd4,
      CSR_MUTED           = 3'd5
   } lctg_csr_index_type;

   typedef struct packed {
      logic [START_INC_W-1:0]   start_increment;
      logic [31:0]              increment_step;
      logic [ENV_STEP_W-1:0]    envelope_step;
      logic [FRAME_COUNT_W-1:0] frame_count;
      logic [VOLUME_W-1:0]      volume;
      logic                     muted;
   } lctg_cfg_type;

   localparam lctg_cfg_type CFG_RESET = '{
      start_increment: '0,
      increment_step:  '0,
      envelope_step:   '0,
      frame_count:     20'd17640,
      volume:          16'd32768,
      muted:           1'b0
   };

   // One tick's worth of work handed from the front end to the synthesis back end.
   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [ENV_W-1:0]   envelope;
      logic               active;
      logic               last;
   } lctg_entry_type;

   // Quarter-wave sine in Q15 from an angle in Q30 (odd Taylor series, nested form).
   function automatic logic [SINE_MAG_W-1:0] sine_q15(input logic [63:0] y);
      logic [63:0] y2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] v;
      y2 = (y * y) >> 30;
      t  = ONE_Q30;
      t  = ONE_Q30 - ((y2 * t) >> 30) / 64'd156;
      t  = ONE_Q30 - ((y2 * t) >> 30) / 64'd110;
      t  = ONE_Q30 - ((y2 * t) >> 30) / 64'd72;
      t  = ONE_Q30 - ((y2 * t) >> 30) / 64'd42;
      t  = ONE_Q30 - ((y2 * t) >> 30) / 64'd20;
      t  = ONE_Q30 - ((y2 * t) >> 30) / 64'd6;
      s  = (y * t) >> 30;
      v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return v[SINE_MAG_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lctg_req_if.sv =====
// Request channel: one sample tick with an optional start request.
`default_nettype none

interface lctg_req_if;
   logic valid;
   logic ready;
   logic start_request;

   modport source (output valid, output start_request, input ready);
   modport sink   (input valid, input start_request, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lctg_rsp_if.sv =====
// Response channel: one audio sample with its tone status flags.
`default_nettype none

interface lctg_rsp_if #(
   parameter int SAMPLE_WIDTH = 16
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample;
   logic                           playing;
   logic                           last_frame;

   modport source (output valid, output sample, output playing, output last_frame,
                   input ready);
   modport sink   (input valid, input sample, input playing, input last_frame,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lctg_csr_if.sv =====
// Configuration write channel: register index and write data.
`default_nettype none

interface lctg_csr_if
   import lctg_pkg::*;
;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/linear_chirp_tone_generator_core.sv =====
// Top level of the linear chirp tone generator: register file, front end, queue, back end.
//
//   channel  dir  handshake    payload
//   req_ch   in   valid/ready  start_request
//   rsp_ch   out  valid/ready  sample, playing, last_frame
//   csr_ch   in   valid/ready  index, data (always ready)
//
// One request transfer per cycle sustained while the queue is not full; the figure is set
// by the combinational phase, increment, envelope and frame update in the front end.
// A result passes from its request transfer through the queue, the address stage, the
// table/gain stage and the output stage, and leaves the output register.
// Reset is synchronous and clears the sweep state, the queue and the pipeline valids;
// the registers return to their reset values.
// A stalled rsp_ch freezes the back end; the two-entry queue takes up the slack and
// req_ch.ready drops only once it is full.
`default_nettype none
`include "linear_chirp_tone_generator_core_assert.svh"

module linear_chirp_tone_generator_core
   import lctg_pkg::*;
#(
   parameter int SINE_TABLE_DEPTH  = 1024,
   parameter int SAMPLE_WIDTH      = 16,
   parameter int FRAME_INDEX_WIDTH = 20
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lctg_req_if.sink   req_ch,
   lctg_rsp_if.source rsp_ch,
   lctg_csr_if.sink   csr_ch
);

   lctg_cfg_type   cfg_ff, cfg_in;
   logic           q_full;
   logic           q_push;
   lctg_entry_type q_push_entry;
   logic           q_head_valid;
   lctg_entry_type q_head_entry;
   logic           q_pop;

   // Register writes always complete in one transfer.
   assign csr_ch.ready = 1'b1;

   // Decode the write index; drop writes to unknown indexes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (lctg_csr_index_type'(csr_ch.index))
            CSR_START_INCREMENT: cfg_in.start_increment = csr_ch.data[START_INC_W-1:0];
            CSR_INCREMENT_STEP:  cfg_in.increment_step  = csr_ch.data[31:0];
            CSR_ENVELOPE_STEP:   cfg_in.envelope_step   = csr_ch.data[ENV_STEP_W-1:0];
            CSR_FRAME_COUNT:     cfg_in.frame_count     = csr_ch.data[FRAME_COUNT_W-1:0];
            CSR_VOLUME:          cfg_in.volume          = csr_ch.data[VOLUME_W-1:0];
            CSR_MUTED:           cfg_in.muted           = csr_ch.data[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: start handling and per-frame sweep update.
   lctg_front #(
      .FRAME_INDEX_WIDTH (FRAME_INDEX_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .cfg        (cfg_ff),
      .q_full     (q_full),
      .push       (q_push),
      .push_entry (q_push_entry)
   );

   // Decouple the sweep update from the sample arithmetic.
   lctg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head_entry (q_head_entry),
      .pop        (q_pop)
   );

   // Back end: sine, gain, envelope and saturation.
   lctg_back #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
      .SAMPLE_WIDTH     (SAMPLE_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_entry (q_head_entry),
      .pop        (q_pop),
      .volume     (cfg_ff.volume),
      .rsp_ch     (rsp_ch)
   );

   `LCTG_ASSERT_IMPL(a_last_only_when_playing, clock, reset, rsp_ch.valid && rsp_ch.last_frame, rsp_ch.playing, "last frame flagged outside a tone")
   `LCTG_ASSERT_IMPL(a_quiet_when_idle, clock, reset, rsp_ch.valid && !rsp_ch.playing, rsp_ch.sample == '0, "non-zero sample outside a tone")

endmodule

`default_nettype wire

// ===== rtl/core/lctg_front.sv =====
// Front end: accepts ticks, applies start requests and advances the sweep state.
`default_nettype none
`include "linear_chirp_tone_generator_core_assert.svh"

module lctg_front
   import lctg_pkg::*;
#(
   parameter int FRAME_INDEX_WIDTH = 20
) (
   input  wire logic           clock,
   input  wire logic           reset,
   lctg_req_if.sink            req_ch,
   input  wire lctg_cfg_type   cfg,
   input  wire logic           q_full,
   output logic                push,
   output lctg_entry_type      push_entry
);

   localparam int CmpW = (FRAME_INDEX_WIDTH + 1 > FRAME_COUNT_W) ?
                         FRAME_INDEX_WIDTH + 1 : FRAME_COUNT_W;

   logic [PHASE_W-1:0]           phase_ff, phase_in;
   logic [PHASE_W-1:0]           incr_ff, incr_in;
   logic [ENV_W-1:0]             env_ff, env_in;
   logic [FRAME_INDEX_WIDTH-1:0] idx_ff, idx_in;
   logic                         active_ff, active_in;

   logic                         accept;
   logic                         start_fire;
   logic [PHASE_W-1:0]           eff_phase;
   logic [PHASE_W-1:0]           eff_incr;
   logic [ENV_W-1:0]             eff_env;
   logic [FRAME_INDEX_WIDTH-1:0] eff_idx;
   logic                         eff_active;
   logic [CmpW-1:0]              idx_plus_one;
   logic                         last;

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign start_fire   = req_ch.start_request && !cfg.muted && (cfg.frame_count != '0);

   // A start reloads the sweep before this tick's sample is taken.
   always_comb begin
      if (start_fire) begin
         eff_phase  = '0;
         eff_incr   = PHASE_W'(cfg.start_increment);
         eff_env    = ENV_ONE;
         eff_idx    = '0;
         eff_active = 1'b1;
      end else begin
         eff_phase  = phase_ff;
         eff_incr   = incr_ff;
         eff_env    = env_ff;
         eff_idx    = idx_ff;
         eff_active = active_ff;
      end
   end

   assign idx_plus_one = CmpW'(eff_idx) + CmpW'(1);
   assign last = (idx_plus_one >= CmpW'(cfg.frame_count)) || (&eff_idx);

   assign push                = accept;
   assign push_entry.phase    = eff_phase;
   assign push_entry.envelope = eff_env;
   assign push_entry.active   = eff_active;
   assign push_entry.last     = eff_active && last;

   always_comb begin
      phase_in  = phase_ff;
      incr_in   = incr_ff;
      env_in    = env_ff;
      idx_in    = idx_ff;
      active_in = active_ff;
      if (accept && eff_active) begin
         phase_in = eff_phase + eff_incr;
         incr_in  = eff_incr + cfg.increment_step;
         // Floor the envelope at zero.
         if (eff_env > ENV_W'(cfg.envelope_step)) begin
            env_in = eff_env - ENV_W'(cfg.envelope_step);
         end else begin
            env_in = '0;
         end
         idx_in    = last ? '0 : eff_idx + FRAME_INDEX_WIDTH'(1);
         active_in = !last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= '0;
         incr_ff   <= '0;
         env_ff    <= '0;
         idx_ff    <= '0;
         active_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         incr_ff   <= incr_in;
         env_ff    <= env_in;
         idx_ff    <= idx_in;
         active_ff <= active_in;
      end
   end

   `LCTG_ASSERT_NEXT(a_start_loads_increment, clock, reset, accept && start_fire, phase_ff == PHASE_W'($past(cfg.start_increment)), "start did not step phase by start increment")

endmodule

`default_nettype wire

// ===== rtl/core/lctg_queue.sv =====
// Two-entry queue between the front end and the synthesis back end.
`default_nettype none

module lctg_queue
   import lctg_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire lctg_entry_type push_entry,
   output logic                full,
   output logic                head_valid,
   output lctg_entry_type      head_entry,
   input  wire logic           pop
);

   lctg_entry_type slot_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/lctg_back.sv =====
// Back end: sine lookup, gain and envelope scaling, saturation and output register.
`default_nettype none

module lctg_back
   import lctg_pkg::*;
#(
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int SAMPLE_WIDTH     = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                head_valid,
   input  wire lctg_entry_type      head_entry,
   output logic                     pop,
   input  wire logic [VOLUME_W-1:0] volume,
   lctg_rsp_if.source               rsp_ch
);

   localparam int DepthW  = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int FracW   = PHASE_W - 2;
   localparam int IdxProdW = FracW + DepthW;
   localparam int GainW   = VOLUME_W + 1;
   localparam int ProdW   = GainW + SINE_MAG_W;
   localparam int MagW    = ProdW + SAMPLE_WIDTH - 1 - 30;
   localparam logic [MagW-1:0] PosMax = MagW'((1 << (SAMPLE_WIDTH - 1)) - 1);
   localparam logic [MagW-1:0] NegLim = MagW'(1 << (SAMPLE_WIDTH - 1));

   // Quarter-wave table, built at elaboration.
   logic [SINE_MAG_W-1:0] rom_tab [SINE_TABLE_DEPTH + 1];

   for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
      localparam logic [63:0] YQ30 = (64'(k) * PI_Q30) / (64'(2 * SINE_TABLE_DEPTH));
      localparam logic [SINE_MAG_W-1:0] EntryQ15 = sine_q15(YQ30);
      assign rom_tab[k] = EntryQ15;
   end

   logic advance;

   // Stage 1: table address from the phase.
   logic              s1_valid_ff;
   logic [DepthW-1:0] s1_addr_ff, s1_addr_in;
   logic              s1_neg_ff;
   logic [ENV_W-1:0]  s1_env_ff;
   logic              s1_active_ff;
   logic              s1_last_ff;
   logic [IdxProdW-1:0] idx_prod;
   logic [DepthW-1:0]   idx_raw;

   // Stage 2: table read and volume times envelope.
   logic                  s2_valid_ff;
   logic [SINE_MAG_W-1:0] s2_mag_ff;
   logic [GainW-1:0]      s2_gain_ff, s2_gain_in;
   logic                  s2_neg_ff;
   logic                  s2_active_ff;
   logic                  s2_last_ff;
   logic [VOLUME_W+ENV_W-1:0] gain_prod;

   // Output stage.
   logic                           out_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] out_sample_ff, out_sample_in;
   logic                           out_playing_ff;
   logic                           out_last_ff;
   logic [ProdW-1:0]               amp_prod;
   logic [ProdW+SAMPLE_WIDTH-2:0]  amp_shifted;
   logic [MagW-1:0]                amp_mag;
   logic [MagW-1:0]                amp_lim;

   assign advance = !out_valid_ff || rsp_ch.ready;
   assign pop     = advance && head_valid;

   assign idx_prod = IdxProdW'(head_entry.phase[FracW-1:0]) * IdxProdW'(SINE_TABLE_DEPTH);
   assign idx_raw  = idx_prod[FracW +: DepthW];

   // Odd quadrants run the table backwards.
   always_comb begin
      if (head_entry.phase[30]) begin
         s1_addr_in = DepthW'(SINE_TABLE_DEPTH) - idx_raw;
      end else begin
         s1_addr_in = idx_raw;
      end
   end

   assign gain_prod  = (VOLUME_W + ENV_W)'(volume) * (VOLUME_W + ENV_W)'(s1_env_ff);
   assign s2_gain_in = gain_prod[31 +: GainW];

   assign amp_prod    = ProdW'(s2_gain_ff) * ProdW'(s2_mag_ff);
   assign amp_shifted = {amp_prod, {(SAMPLE_WIDTH - 1){1'b0}}};
   assign amp_mag     = amp_shifted[30 +: MagW];

   // Clip to the signed sample range.
   always_comb begin
      amp_lim       = amp_mag;
      out_sample_in = '0;
      if (s2_active_ff) begin
         if (s2_neg_ff) begin
            if (amp_mag > NegLim) begin
               amp_lim = NegLim;
            end
            out_sample_in = SAMPLE_WIDTH'(~amp_lim + MagW'(1));
         end else begin
            if (amp_mag > PosMax) begin
               amp_lim = PosMax;
            end
            out_sample_in = SAMPLE_WIDTH'(amp_lim);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= head_valid;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_addr_ff     <= s1_addr_in;
         s1_neg_ff      <= head_entry.phase[31];
         s1_env_ff      <= head_entry.envelope;
         s1_active_ff   <= head_entry.active;
         s1_last_ff     <= head_entry.last;
         s2_mag_ff      <= rom_tab[s1_addr_ff];
         s2_gain_ff     <= s2_gain_in;
         s2_neg_ff      <= s1_neg_ff;
         s2_active_ff   <= s1_active_ff;
         s2_last_ff     <= s1_last_ff;
         out_sample_ff  <= out_sample_in;
         out_playing_ff <= s2_active_ff;
         out_last_ff    <= s2_last_ff;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.sample     = out_sample_ff;
   assign rsp_ch.playing    = out_playing_ff;
   assign rsp_ch.last_frame = out_last_ff;

endmodule

`default_nettype wire

// ===== tb/sv/linear_chirp_tone_generator_core_test.sv =====
// Self-checking testbench for the linear chirp tone generator core.
`timescale 1ns / 100ps

module linear_chirp_tone_generator_core_test;
   import lctg_pkg::*;

   localparam int SAMPLE_W      = 16;
   localparam int TABLE_DEPTH   = 1024;
   localparam int FRAME_W       = 20;
   localparam int QUIET_LIMIT   = 4000;
   localparam int SEGMENTS      = 8;
   localparam int SEGMENT_TICKS = 50;
   localparam int SETTLE_CYCLES = 20;
   // An index past the end of the register map; writes to it must be ignored.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 3'd7;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       playing;
      logic                       last_frame;
   } chirp_sample_type;

   typedef enum logic [1:0] {
      ROW_WRITE,
      ROW_TICK,
      ROW_TICK_KNOWN
   } drill_kind_type;

   typedef struct packed {
      drill_kind_type          kind;
      logic [CSR_INDEX_W-1:0]  index;
      logic [CSR_DATA_W-1:0]   data;
      logic                    start;
      chirp_sample_type        known;
   } drill_row_type;

   logic clock;
   logic reset;

   lctg_req_if                              req_ch ();
   lctg_rsp_if #(.SAMPLE_WIDTH(SAMPLE_W))   rsp_ch ();
   lctg_csr_if                              csr_ch ();

   linear_chirp_tone_generator_core #(
      .SINE_TABLE_DEPTH (TABLE_DEPTH),
      .SAMPLE_WIDTH     (SAMPLE_W),
      .FRAME_INDEX_WIDTH(FRAME_W)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   // Register copy and sweep state of the predictor.
   lctg_cfg_type       sweep_cfg;
   logic [31:0]        tone_phase;
   logic [31:0]        tone_increment;
   logic [31:0]        tone_envelope;
   logic [FRAME_W-1:0] tone_frame;
   logic               tone_active;

   int unsigned      quarter_wave [0:TABLE_DEPTH];
   chirp_sample_type pending_samples [$];
   drill_row_type    drill [$];
   int               mismatch_count = 0;
   int               gap_pct = 0;
   int               stall_pct = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Quarter-wave sine in Q15, nested odd Taylor series evaluated in Q30.
   function automatic void build_quarter_wave();
      logic [63:0] angle;
      logic [63:0] angle_sq;
      logic [63:0] series;
      logic [63:0] partial;
      logic [63:0] level;
      int unsigned divs [6];
      int          k;
      int          d;
      divs = '{156, 110, 72, 42, 20, 6};
      for (k = 0; k <= TABLE_DEPTH; k++) begin
         angle = 64'(k);
         angle = (angle * PI_Q30) / 64'(2 * TABLE_DEPTH);
         angle_sq = (angle * angle) >> 30;
         series = ONE_Q30;
         for (d = 0; d < 6; d++) begin
            series = ONE_Q30 - ((angle_sq * series) >> 30) / 64'(divs[d]);
         end
         partial = (angle * series) >> 30;
         level = (partial * 64'd32767 + (64'd1 << 29)) >> 30;
         if (level > 64'd32767) begin
            level = 64'd32767;
         end
         quarter_wave[k] = level[31:0];
      end
   endfunction

   // Gain times envelope times sine, magnitude truncated, then saturated.
   function automatic logic signed [SAMPLE_W-1:0] shaped_sample(input logic [31:0] phase);
      logic [9:0]  slot;
      logic [63:0] level;
      logic [63:0] gain;
      logic [63:0] mag;
      slot  = phase[29:20];
      level = phase[30] ? 64'(quarter_wave[TABLE_DEPTH - slot]) : 64'(quarter_wave[slot]);
      gain  = 64'(sweep_cfg.volume);
      gain  = (gain * tone_envelope) >> 31;
      mag   = ((gain * level) << (SAMPLE_W - 1)) >> 30;
      if (phase[31]) begin
         if (mag > (64'd1 << (SAMPLE_W - 1))) begin
            mag = 64'd1 << (SAMPLE_W - 1);
         end
         mag = 64'd0 - mag;
      end else if (mag > (64'd1 << (SAMPLE_W - 1)) - 1) begin
         mag = (64'd1 << (SAMPLE_W - 1)) - 1;
      end
      return mag[SAMPLE_W-1:0];
   endfunction

   // Produce the sample of one tick and step the sweep on by one frame.
   function automatic chirp_sample_type advance_chirp(input logic start);
      chirp_sample_type result;
      logic             closing;
      result = '0;
      if (start && !sweep_cfg.muted && sweep_cfg.frame_count != '0) begin
         tone_active    = 1'b1;
         tone_frame     = '0;
         tone_phase     = '0;
         tone_increment = {1'b0, sweep_cfg.start_increment};
         tone_envelope  = ENV_ONE;
      end
      if (!tone_active) begin
         return result;
      end
      closing = ({12'd0, tone_frame} + 32'd1 >= {12'd0, sweep_cfg.frame_count})
                || (tone_frame == '1);
      result.sample     = shaped_sample(tone_phase);
      result.playing    = 1'b1;
      result.last_frame = closing;
      tone_phase     = tone_phase + tone_increment;
      tone_increment = tone_increment + sweep_cfg.increment_step;
      tone_envelope  = (tone_envelope > {1'b0, sweep_cfg.envelope_step})
                       ? tone_envelope - {1'b0, sweep_cfg.envelope_step} : '0;
      tone_frame     = tone_frame + FRAME_W'(1);
      if (closing) begin
         tone_active = 1'b0;
         tone_frame  = '0;
      end
      return result;
   endfunction

   function automatic void apply_register(input logic [CSR_INDEX_W-1:0] index,
                                          input logic [CSR_DATA_W-1:0] data);
      case (index)
         CSR_START_INCREMENT: begin
            sweep_cfg.start_increment = data[START_INC_W-1:0];
         end
         CSR_INCREMENT_STEP: begin
            sweep_cfg.increment_step = data;
         end
         CSR_ENVELOPE_STEP: begin
            sweep_cfg.envelope_step = data[ENV_STEP_W-1:0];
         end
         CSR_FRAME_COUNT: begin
            sweep_cfg.frame_count = data[FRAME_COUNT_W-1:0];
         end
         CSR_VOLUME: begin
            sweep_cfg.volume = data[VOLUME_W-1:0];
         end
         CSR_MUTED: begin
            sweep_cfg.muted = data[0];
         end
         default: begin
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Directed table rows
   // ------------------------------------------------------------------

   function automatic drill_row_type set_reg(input logic [CSR_INDEX_W-1:0] index,
                                             input logic [CSR_DATA_W-1:0] data);
      drill_row_type row;
      row       = '0;
      row.kind  = ROW_WRITE;
      row.index = index;
      row.data  = data;
      return row;
   endfunction

   function automatic drill_row_type tick(input logic start);
      drill_row_type row;
      row       = '0;
      row.kind  = ROW_TICK;
      row.start = start;
      return row;
   endfunction

   function automatic drill_row_type tick_is(input logic start, input int sample,
                                             input logic playing, input logic last_frame);
      drill_row_type row;
      row                  = '0;
      row.kind             = ROW_TICK_KNOWN;
      row.start            = start;
      row.known.sample     = sample[SAMPLE_W-1:0];
      row.known.playing    = playing;
      row.known.last_frame = last_frame;
      return row;
   endfunction

   // ------------------------------------------------------------------
   // Channel drivers: drive on the falling edge, sample on the rising edge
   // ------------------------------------------------------------------

   // Leaves csr valid high so that writes can follow back to back; the caller
   // drops it after the last one.
   task automatic program_register(input logic [CSR_INDEX_W-1:0] index,
                                   input logic [CSR_DATA_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      apply_register(index, data);
      @(negedge clock);
   endtask

   // Send one tick. Optionally hold until every sample in flight has come back.
   task automatic send_tick(input logic start, input bit hold, input bit typed,
                            input chirp_sample_type typed_value);
      chirp_sample_type predicted;
      while (hold && pending_samples.size() != 0) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      while ($urandom_range(0, 99) < gap_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.start_request <= start;
      do @(posedge clock); while (!req_ch.ready);
      predicted = advance_chirp(start);
      pending_samples.push_back(typed ? typed_value : predicted);
      @(negedge clock);
   endtask

   // Drop the request and wait until the core has nothing left in flight.
   task automatic settle_block();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (pending_samples.size() != 0) @(negedge clock);
   endtask

   // Draw a fresh sweep setting, extremes included, and write all or a random part of it while idle.
   task automatic pick_sweep_settings(input bit write_all);
      logic [31:0] start_inc;
      logic [31:0] inc_step;
      logic [31:0] env_step;
      logic [31:0] frames;
      logic [31:0] gain;
      logic [31:0] mute;
      case ($urandom_range(0, 5))
         0:       start_inc = 32'h0;
         1:       start_inc = 32'h7FFF_FFFF;
         2:       start_inc = $urandom;
         default: start_inc = $urandom_range(0, 32'h0800_0000);
      endcase
      case ($urandom_range(0, 5))
         0:       inc_step = 32'h0;
         1:       inc_step = 32'h8000_0000;
         2:       inc_step = 32'h7FFF_FFFF;
         3:       inc_step = $urandom;
         default: begin
            inc_step = $urandom_range(0, 1 << 20);
            if ($urandom_range(0, 1) == 1) begin
               inc_step = 32'd0 - inc_step;
            end
         end
      endcase
      case ($urandom_range(0, 9))
         0:       frames = 32'd0;
         1:       frames = 32'd1;
         2:       frames = $urandom_range(25, 300);
         3:       frames = 32'd1048575;
         default: frames = $urandom_range(2, 24);
      endcase
      case ($urandom_range(0, 5))
         0:       env_step = 32'h0;
         1:       env_step = 32'h4000_0000;
         2:       env_step = 32'h7FFF_FFFF | ($urandom & 32'h8000_0000);
         3:       env_step = $urandom;
         default: env_step = (frames == 0) ? 32'h0 : 32'h4000_0000 / frames;
      endcase
      case ($urandom_range(0, 5))
         0:       gain = 32'd0;
         1:       gain = 32'd32768;
         2:       gain = 32'd65535;
         3:       gain = $urandom;
         default: gain = $urandom_range(0, 32768);
      endcase
      // Junk in the unused data bits must not leak into the registers.
      frames = frames | ($urandom & 32'hFFF0_0000);
      mute   = ($urandom & 32'hFFFF_FFFE) | 32'($urandom_range(0, 4) == 0);
      if (write_all || $urandom_range(0, 3) != 0) program_register(CSR_START_INCREMENT, start_inc);
      if (write_all || $urandom_range(0, 3) != 0) program_register(CSR_INCREMENT_STEP, inc_step);
      if (write_all || $urandom_range(0, 3) != 0) program_register(CSR_FRAME_COUNT, frames);
      if (write_all || $urandom_range(0, 3) != 0) program_register(CSR_ENVELOPE_STEP, env_step);
      if (write_all || $urandom_range(0, 3) != 0) program_register(CSR_VOLUME, gain);
      if (write_all || $urandom_range(0, 3) != 0) program_register(CSR_MUTED, mute);
      csr_ch.valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Result checking: compare every sample transfer with the oldest prediction
   // ------------------------------------------------------------------
   always @(posedge clock) begin : check_samples
      chirp_sample_type due;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_samples.size() == 0) begin
            $display("%0t: unexpected sample %0d (playing %0b, last %0b)", $time,
                     rsp_ch.sample, rsp_ch.playing, rsp_ch.last_frame);
            mismatch_count++;
         end else begin
            due = pending_samples.pop_front();
            if (rsp_ch.sample !== due.sample) begin
               $display("%0t: sample: expected %0d, actual %0d", $time,
                        due.sample, rsp_ch.sample);
               mismatch_count++;
            end
            if (rsp_ch.playing !== due.playing) begin
               $display("%0t: playing: expected %0b, actual %0b", $time,
                        due.playing, rsp_ch.playing);
               mismatch_count++;
            end
            if (rsp_ch.last_frame !== due.last_frame) begin
               $display("%0t: last_frame: expected %0b, actual %0b", $time,
                        due.last_frame, rsp_ch.last_frame);
               mismatch_count++;
            end
         end
      end
   end

   // Randomly stall the sample consumer at the rate of the current segment.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Watchdog: give up once no transfer of any kind has happened for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
             || (csr_ch.valid && csr_ch.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("linear_chirp_tone_generator_core_test failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin : stimulus
      int             r;
      int             seg;
      int             n;
      int             gap_by_profile [4];
      int             stall_by_profile [4];
      drill_row_type  row;
      logic           prev_write;

      // Hold every input at a known value before the first edge.
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.start_request = 1'b0;
      csr_ch.valid         = 1'b0;
      csr_ch.index         = '0;
      csr_ch.data          = '0;

      // Profiles: no idling, idle sender, stalling receiver, both.
      gap_by_profile   = '{0, 85, 0, 37};
      stall_by_profile = '{0, 0, 85, 37};

      build_quarter_wave();
      sweep_cfg      = CFG_RESET;
      tone_phase     = '0;
      tone_increment = '0;
      tone_envelope  = '0;
      tone_frame     = '0;
      tone_active    = 1'b0;

      // Typed expectations are only given where they follow at a glance:
      // the idle output, a sine at phase zero or a half turn, a silenced gain, or full
      // saturation with an over-range volume at the quarter-turn phases.
      drill = '{
         tick_is(1'b0, 0, 1'b0, 1'b0),                 // idle after reset
         tick_is(1'b1, 0, 1'b1, 1'b0),                 // zero increment: phase stays put
         tick_is(1'b0, 0, 1'b1, 1'b0),
         set_reg(CSR_FRAME_COUNT, 32'd1),
         tick_is(1'b1, 0, 1'b1, 1'b1),                 // restart into a one-frame tone
         tick_is(1'b0, 0, 1'b0, 1'b0),
         set_reg(CSR_START_INCREMENT, 32'h4000_0000),
         set_reg(CSR_VOLUME, 32'h0000_FFFF),
         set_reg(CSR_FRAME_COUNT, 32'd4),
         tick_is(1'b1, 0, 1'b1, 1'b0),                 // quarter turns, saturating gain
         tick_is(1'b0, 32767, 1'b1, 1'b0),
         tick_is(1'b0, 0, 1'b1, 1'b0),
         tick_is(1'b0, -32768, 1'b1, 1'b1),
         tick_is(1'b0, 0, 1'b0, 1'b0),
         set_reg(CSR_MUTED, 32'd1),
         tick_is(1'b1, 0, 1'b0, 1'b0),                 // start while muted is dropped
         set_reg(CSR_MUTED, 32'd0),
         set_reg(CSR_VOLUME, 32'd32768),
         set_reg(CSR_INCREMENT_STEP, 32'h8000_0000),
         set_reg(CSR_ENVELOPE_STEP, 32'h7FFF_FFFF),     // envelope runs out and clamps
         set_reg(CSR_START_INCREMENT, 32'h7FFF_FFFF),
         set_reg(CSR_FRAME_COUNT, 32'd8),
         tick(1'b1),
         tick(1'b0),
         set_reg(CSR_MUTED, 32'd1),                     // mute mid-tone: tone plays on
         tick(1'b1),
         tick(1'b0),
         set_reg(CSR_MUTED, 32'hFFFF_FFFE),
         set_reg(CSR_INCREMENT_STEP, 32'h7FFF_FFFF),
         set_reg(CSR_ENVELOPE_STEP, 32'd0),
         tick(1'b0),
         tick(1'b1),                                    // restart mid-tone
         tick(1'b0),
         tick(1'b0),
         set_reg(CSR_FRAME_COUNT, 32'd2),               // length cut below the frame
         tick(1'b0),
         set_reg(CSR_FRAME_COUNT, 32'd0),
         tick_is(1'b1, 0, 1'b0, 1'b0),                 // zero length starts nothing
         set_reg(CSR_FRAME_COUNT, 32'hFFFF_FFFF),
         set_reg(CSR_VOLUME, 32'd0),
         set_reg(CSR_INCREMENT_STEP, 32'hFFFF_FFFF),
         set_reg(CSR_ENVELOPE_STEP, 32'h4000_0000),
         set_reg(CSR_SPARE_INDEX, 32'hFFFF_FFFF),
         tick(1'b1),
         tick_is(1'b0, 0, 1'b1, 1'b0),                 // zero volume
         set_reg(CSR_VOLUME, 32'd32768),
         set_reg(CSR_START_INCREMENT, 32'hFFFF_FFFF),   // only felt at the next start
         tick(1'b0),
         tick(1'b1)
      };

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the table. Settle the core before the first write of each run of
      // writes; release the config channel after the last one.
      prev_write = 1'b0;
      for (r = 0; r < drill.size(); r++) begin
         row = drill[r];
         if (row.kind == ROW_WRITE) begin
            if (!prev_write) begin
               settle_block();
            end
            program_register(row.index, row.data);
            if (r + 1 == drill.size() || drill[r + 1].kind != ROW_WRITE) begin
               csr_ch.valid <= 1'b0;
            end
            prev_write = 1'b1;
         end else begin
            send_tick(row.start, 1'b0, row.kind == ROW_TICK_KNOWN, row.known);
            prev_write = 1'b0;
         end
      end

      // Random part: segments of chirps under a fresh setting, cycling
      // through the idling profiles twice.
      for (seg = 0; seg < SEGMENTS; seg++) begin
         settle_block();
         gap_pct   = gap_by_profile[seg % 4];
         stall_pct = stall_by_profile[seg % 4];
         pick_sweep_settings(seg == 0);
         for (n = 0; n < SEGMENT_TICKS; n++) begin
            // Start rarely so that most tones run through to their last frame;
            // now and then hold the request until the pipeline has drained.
            send_tick($urandom_range(0, 15) == 0, $urandom_range(0, 39) == 0, 1'b0, '0);
         end
      end

      settle_block();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("linear_chirp_tone_generator_core_test passed");
      end else begin
         $display("linear_chirp_tone_generator_core_test failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/lctg_pkg.sv
rtl/core/lctg_req_if.sv
rtl/core/lctg_rsp_if.sv
rtl/core/lctg_csr_if.sv
rtl/core/lctg_front.sv
rtl/core/lctg_queue.sv
rtl/core/lctg_back.sv
rtl/core/linear_chirp_tone_generator_core.sv
tb/sv/linear_chirp_tone_generator_core_test.sv
